// ===== hw/rtl/drt_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drt_pkg: shared types and constants of the dirty rectangle tracker
// Request codes, queue command codes, rectangle and command records and the
// register map of the configuration port.
// ============================================================================
package drt_pkg;

    // Request codes carried by s_req_type.
    localparam logic [1:0] REQ_MARK   = 2'd0;
    localparam logic [1:0] REQ_SPRITE = 2'd1;
    localparam logic [1:0] REQ_DRAW   = 2'd2;
    localparam logic [1:0] REQ_FORCE  = 2'd3;

    // Command codes passed from the front end to the back end.
    localparam logic [1:0] CMD_MARK  = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;

    // Register indexes of the configuration port.
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // Register reset values.
    localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;

    // Border added to every marked rectangle in width and height.
    localparam logic [12:0] MARK_BORDER = 13'd4;

    // Command queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // One widened rectangle as stored in the list (50 bits).
    typedef struct packed {
        logic signed [12:0] x;
        logic signed [12:0] y;
        logic [11:0]        w;
        logic [11:0]        h;
    } rect_t;

    // One command in the queue between front and back end.
    typedef struct packed {
        logic [1:0] op;
        rect_t      rect;
    } cmd_t;

    // Screen size seen by the back end.
    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
    } screen_cfg_t;

endpackage

// ===== hw/rtl/dirty_rectangle_tracker.sv =====
`timescale 1ns / 1ps
// Path: a full-screen result passes the front-end holding register, a queue slot
// and the output register; a stored rectangle also passes the drain state and the
// registered list read. The front end takes no new request until the held one, both
// halves of a split sprite move, is pushed; a draw drains one stored rectangle per
// cycle while the output is free. Reset: count cleared, full-redraw flag set,
// registers 640 by 480; the list itself is not cleared and needs no clearing pass.
// ============================================================================
// dirty_rectangle_tracker: damaged screen region collector
// Top level: configuration registers, request front end, command queue and
// rectangle list back end.
// ============================================================================
module dirty_rectangle_tracker
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [11:0] s_pos_x,
    input  logic signed [11:0] s_pos_y,
    input  logic signed [11:0] s_new_x,
    input  logic signed [11:0] s_new_y,
    input  logic [10:0]        s_size_w,
    input  logic [10:0]        s_size_h,
    // Result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [12:0] m_rect_x,
    output logic signed [12:0] m_rect_y,
    output logic [11:0]        m_rect_w,
    output logic [11:0]        m_rect_h,
    output logic               m_full_screen,
    output logic               m_last
);

    logic [11:0] screen_width_reg, screen_height_reg;
    screen_cfg_t cfg;
    logic        cfg_write;

    logic        q_push, q_full, q_pop, q_valid;
    cmd_t        push_cmd, head_cmd;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SCREEN_WIDTH) begin
                screen_width_reg <= pwdata[11:0];
            end else begin
                screen_height_reg <= pwdata[11:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SCREEN_HEIGHT) ? {20'd0, screen_height_reg}
                                                    : {20'd0, screen_width_reg};

    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;

    // Request intake.
    drt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_new_x    (s_new_x),
        .s_new_y    (s_new_y),
        .s_size_w   (s_size_w),
        .s_size_h   (s_size_h),
        .q_push     (q_push),
        .q_cmd      (push_cmd),
        .q_full     (q_full)
    );

    // Command queue.
    drt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    // Rectangle list and draw sequencer.
    drt_back #(
        .MAX_RECTS (MAX_RECTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_cmd         (head_cmd),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_x      (m_rect_x),
        .m_rect_y      (m_rect_y),
        .m_rect_w      (m_rect_w),
        .m_rect_h      (m_rect_h),
        .m_full_screen (m_full_screen),
        .m_last        (m_last)
    );

endmodule

// ===== hw/rtl/drt_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drt_front: request intake and classification
// Holds one request, widens mark rectangles, coalesces or splits sprite moves
// and pushes one or two commands into the command queue.
// ============================================================================
module drt_front
    import drt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_req_type,
    input  logic signed [11:0] s_pos_x,
    input  logic signed [11:0] s_pos_y,
    input  logic signed [11:0] s_new_x,
    input  logic signed [11:0] s_new_y,
    input  logic [10:0]        s_size_w,
    input  logic [10:0]        s_size_h,
    output logic               q_push,
    output cmd_t               q_cmd,
    input  logic               q_full
);

    logic               item_valid_reg, item_valid_next;
    logic               phase_reg, phase_next;
    logic [1:0]         req_reg;
    logic signed [11:0] px_reg, py_reg, nx_reg, ny_reg;
    logic [10:0]        sw_reg, sh_reg;

    logic signed [12:0] dx, dy;
    logic [11:0]        abs_dx, abs_dy;
    logic               coalesce;
    logic signed [11:0] min_x, min_y;
    logic               accept;

    assign s_ready = !item_valid_reg;
    assign accept  = s_valid && s_ready;

    // Request holding register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req_type;
            px_reg  <= s_pos_x;
            py_reg  <= s_pos_y;
            nx_reg  <= s_new_x;
            ny_reg  <= s_new_y;
            sw_reg  <= s_size_w;
            sh_reg  <= s_size_h;
        end
    end

    // Sprite offsets and the coalescing test.
    always_comb begin
        dx       = {nx_reg[11], nx_reg} - {px_reg[11], px_reg};
        dy       = {ny_reg[11], ny_reg} - {py_reg[11], py_reg};
        abs_dx   = dx[12] ? 12'(-dx) : dx[11:0];
        abs_dy   = dy[12] ? 12'(-dy) : dy[11:0];
        coalesce = (abs_dx < {2'b00, sw_reg[10:1]}) && (abs_dy < {2'b00, sh_reg[10:1]});
        min_x    = (nx_reg < px_reg) ? nx_reg : px_reg;
        min_y    = (ny_reg < py_reg) ? ny_reg : py_reg;
    end

    // Command build and sequencing of split sprite moves.
    always_comb begin
        logic signed [11:0] base_x;
        logic signed [11:0] base_y;
        logic [12:0]        ext_w;
        logic [12:0]        ext_h;
        logic               done;

        base_x = px_reg;
        base_y = py_reg;
        ext_w  = {2'b00, sw_reg};
        ext_h  = {2'b00, sh_reg};
        done   = 1'b1;
        q_cmd.op = CMD_MARK;

        case (req_reg)
            REQ_MARK: begin
                q_cmd.op = CMD_MARK;
            end
            REQ_SPRITE: begin
                q_cmd.op = CMD_MARK;
                if (coalesce) begin
                    base_x = min_x;
                    base_y = min_y;
                    ext_w  = {1'b0, abs_dx} + {2'b00, sw_reg};
                    ext_h  = {1'b0, abs_dy} + {2'b00, sh_reg};
                end else if (phase_reg) begin
                    base_x = nx_reg;
                    base_y = ny_reg;
                end else begin
                    done = 1'b0;
                end
            end
            REQ_DRAW: begin
                q_cmd.op = CMD_DRAW;
            end
            default: begin
                q_cmd.op = CMD_FORCE;
            end
        endcase

        q_cmd.rect.x = {base_x[11], base_x} - 13'sd1;
        q_cmd.rect.y = {base_y[11], base_y} - 13'sd1;
        q_cmd.rect.w = 12'(ext_w + MARK_BORDER);
        q_cmd.rect.h = 12'(ext_h + MARK_BORDER);

        q_push          = item_valid_reg && !q_full;
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        if (accept) begin
            item_valid_next = 1'b1;
            phase_next      = 1'b0;
        end else if (q_push) begin
            if (done) begin
                item_valid_next = 1'b0;
                phase_next      = 1'b0;
            end else begin
                phase_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
        end
    end

endmodule

// ===== hw/rtl/drt_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drt_queue: command queue between front and back end
// A small first-in first-out buffer of commands; the head is read directly.
// ============================================================================
module drt_queue
    import drt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   fill_reg, fill_next;
    logic                do_push, do_pop;

    assign full       = (fill_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/drt_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// drt_back: rectangle list and draw sequencer
// Executes queued commands against the rectangle list and the full-redraw
// flag, and drains the list one result per cycle while the output is free on a draw request.
// ============================================================================
module drt_back
    import drt_pkg::*;
#(
    parameter int MAX_RECTS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  screen_cfg_t        cfg,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [12:0] m_rect_x,
    output logic signed [12:0] m_rect_y,
    output logic [11:0]        m_rect_w,
    output logic [11:0]        m_rect_h,
    output logic               m_full_screen,
    output logic               m_last
);

    localparam int CW = $clog2(MAX_RECTS + 1);
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    rect_t   mem [MAX_RECTS];
    rect_t   rd_data_reg;

    logic          state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          flag_reg, flag_next;
    logic          m_valid_reg, m_valid_next;
    logic          fs_reg, fs_next;
    logic          last_reg, last_next;
    logic          mem_we, rd_en;
    logic          out_free;
    logic          list_full;
    logic          drain_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign list_full  = (count_reg == CW'(MAX_RECTS));
    assign drain_last = ((idx_reg + 1'b1) == count_reg);

    // Command execution and drain sequencing.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        flag_next    = flag_reg;
        fs_next      = fs_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        CMD_MARK: begin
                            q_pop = 1'b1;
                            if (flag_reg || list_full) begin
                                flag_next = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_DRAW: begin
                            if (flag_reg) begin
                                if (out_free) begin
                                    q_pop        = 1'b1;
                                    m_valid_next = 1'b1;
                                    fs_next      = 1'b1;
                                    last_next    = 1'b1;
                                    flag_next    = 1'b0;
                                    count_next   = '0;
                                end
                            end else if (count_reg == '0) begin
                                q_pop = 1'b1;
                            end else begin
                                q_pop      = 1'b1;
                                idx_next   = '0;
                                state_next = ST_DRAIN;
                            end
                        end
                        CMD_FORCE: begin
                            q_pop     = 1'b1;
                            flag_next = 1'b1;
                        end
                        default: begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DRAIN: begin
                if (out_free) begin
                    rd_en        = 1'b1;
                    m_valid_next = 1'b1;
                    fs_next      = 1'b0;
                    last_next    = drain_last;
                    idx_next     = idx_reg + 1'b1;
                    if (drain_last) begin
                        count_next = '0;
                        flag_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            flag_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            fs_reg      <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
            fs_reg      <= fs_next;
            last_reg    <= last_next;
        end
    end

    // Rectangle list: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[AW-1:0]] <= q_cmd.rect;
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    // Result fields: the full-screen result overrides the read data.
    assign m_valid       = m_valid_reg;
    assign m_rect_x      = fs_reg ? 13'sd0 : rd_data_reg.x;
    assign m_rect_y      = fs_reg ? 13'sd0 : rd_data_reg.y;
    assign m_rect_w      = fs_reg ? cfg.screen_width : rd_data_reg.w;
    assign m_rect_h      = fs_reg ? cfg.screen_height : rd_data_reg.h;
    assign m_full_screen = fs_reg;
    assign m_last        = last_reg;

`ifndef NO_ASSERTIONS
    // The list never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RECTS))
        else $error("rectangle count above list size");

    // A drain only reads entries that were written.
    a_drain_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (idx_reg < count_reg))
        else $error("drain index past stored entries");

    // A drain runs only while no full redraw is pending.
    a_drain_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> !flag_reg)
        else $error("drain with full redraw pending");

    // A command is taken from the queue only when one is there.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("command pop from empty queue");
`endif

endmodule
